FILE: hw/rtl/rqsr_pkg.sv
// Shared types and constants for the ring queue with rotate search.
// Used by the channel interfaces, the sequencer, the slot store and the top level.
package rqsr_pkg;

   localparam int KEY_W     = 32;
   localparam int CNT_W     = 5;
   localparam int OP_W      = 2;
   localparam int ST_W      = 2;
   localparam int DEPTH_DEF = 16;

   typedef enum logic [OP_W-1:0] {
      OP_ENQ    = 2'd0,
      OP_DEQ    = 2'd1,
      OP_SEARCH = 2'd2
   } op_type;

   typedef enum logic [ST_W-1:0] {
      ST_OK       = 2'd0,
      ST_FULL     = 2'd1,
      ST_EMPTY    = 2'd2,
      ST_NOTFOUND = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_ISSUE,
      S_CHECK,
      S_DONE
   } state_type;

   // one-hot style commands from the sequencer to the slot store
   typedef struct packed {
      logic read_head;
      logic push_key;
      logic pop;
      logic requeue;
   } cmd_type;

   typedef struct packed {
      logic [KEY_W-1:0] value;
      logic [CNT_W-1:0] moved_count;
      status_type       status;
      logic [CNT_W-1:0] occupancy;
   } res_type;

endpackage

FILE: hw/rtl/rqsr_req_if.sv
// Request channel: valid/ready handshake carrying operation and key.
// Depends on rqsr_pkg for field widths.
interface rqsr_req_if;
   import rqsr_pkg::*;

   logic                    valid;
   logic                    ready;
   logic [OP_W-1:0]         operation;
   logic signed [KEY_W-1:0] key;

   modport source (output valid, output operation, output key, input ready);
   modport sink (input valid, input operation, input key, output ready);
endinterface

FILE: hw/rtl/rqsr_rsp_if.sv
// Response channel: valid/ready handshake carrying value, moved count, status
// and occupancy. Depends on rqsr_pkg for field widths.
interface rqsr_rsp_if;
   import rqsr_pkg::*;

   logic                    valid;
   logic                    ready;
   logic signed [KEY_W-1:0] value;
   logic [CNT_W-1:0]        moved_count;
   logic [ST_W-1:0]         status;
   logic [CNT_W-1:0]        occupancy;

   modport source (output valid, output value, output moved_count, output status,
                   output occupancy, input ready);
   modport sink (input valid, input value, input moved_count, input status,
                 input occupancy, output ready);
endinterface

FILE: hw/rtl/rqsr_store.sv
// Slot store: circular slot memory with head index and entry count.
// Executes read, push, pop and requeue commands; depends on rqsr_pkg.
module rqsr_store #(
   parameter int DEPTH = rqsr_pkg::DEPTH_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  rqsr_pkg::cmd_type               cmd,
   input  logic [rqsr_pkg::KEY_W-1:0]      key,
   output logic [rqsr_pkg::KEY_W-1:0]      rd_data,
   output logic [$clog2(DEPTH+1)-1:0]      count
);
   import rqsr_pkg::*;

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int SW = CW + 1;

   logic [KEY_W-1:0] slots_ff [DEPTH];
   logic [KEY_W-1:0] rd_data_ff;
   logic [AW-1:0]    head_ff, head_in;
   logic [CW-1:0]    count_ff, count_in;

   logic [SW-1:0]    tail_sum;
   logic [AW-1:0]    tail_idx;
   logic [AW-1:0]    head_inc;
   logic             last;
   logic             wr_en;
   logic [AW-1:0]    wr_addr;
   logic [KEY_W-1:0] wr_data;

   always_comb begin
      tail_sum = SW'(head_ff) + SW'(count_ff);
      tail_idx = (tail_sum >= SW'(DEPTH)) ? AW'(tail_sum - SW'(DEPTH)) : AW'(tail_sum);
      head_inc = (head_ff == AW'(DEPTH - 1)) ? '0 : head_ff + AW'(1);
      last     = (count_ff == CW'(1));
   end

   always_comb begin
      head_in  = head_ff;
      count_in = count_ff;
      wr_en    = 1'b0;
      wr_addr  = tail_idx;
      wr_data  = key;
      priority if (cmd.push_key) begin
         wr_en    = 1'b1;
         count_in = count_ff + CW'(1);
      end else if (cmd.pop) begin
         head_in  = last ? '0 : head_inc;
         count_in = count_ff - CW'(1);
      end else if (cmd.requeue) begin
         // pop then push: a single entry lands back in slot zero
         wr_en   = 1'b1;
         wr_addr = last ? '0 : tail_idx;
         wr_data = rd_data_ff;
         head_in = last ? '0 : head_inc;
      end else begin
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         slots_ff[wr_addr] <= wr_data;
      end
      if (cmd.read_head) begin
         rd_data_ff <= slots_ff[head_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         count_ff <= count_in;
      end
   end

   assign rd_data = rd_data_ff;
   assign count   = count_ff;

endmodule

FILE: hw/rtl/rqsr_seq.sv
// Sequencer: takes one request, drives the slot store and the key comparator
// step by step, and builds the result. Depends on rqsr_pkg.
module rqsr_seq #(
   parameter int DEPTH = rqsr_pkg::DEPTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [rqsr_pkg::OP_W-1:0]     req_operation,
   input  logic [rqsr_pkg::KEY_W-1:0]    req_key,
   output rqsr_pkg::cmd_type             cmd,
   output logic [rqsr_pkg::KEY_W-1:0]    key,
   input  logic [rqsr_pkg::KEY_W-1:0]    rd_data,
   input  logic [$clog2(DEPTH+1)-1:0]    count,
   output logic                          res_valid,
   input  logic                          res_ready,
   output rqsr_pkg::res_type             res
);
   import rqsr_pkg::*;

   localparam int CW = $clog2(DEPTH + 1);

   state_type        state_ff, state_in;
   logic [OP_W-1:0]  op_ff, op_in;
   logic [KEY_W-1:0] key_ff, key_in;
   logic [CW-1:0]    left_ff, left_in;
   logic [CW-1:0]    moved_ff, moved_in;
   logic [KEY_W-1:0] value_ff, value_in;
   status_type       status_ff, status_in;

   logic accept;
   logic hit;

   assign accept = req_valid && (state_ff == S_IDLE);
   assign hit    = (op_ff == OP_DEQ) || (rd_data == key_ff);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) state_in = S_ISSUE;
         end
         S_ISSUE: begin
            unique case (op_ff)
               OP_DEQ:    state_in = (count == '0) ? S_DONE : S_CHECK;
               OP_SEARCH: state_in = (left_ff == '0) ? S_DONE : S_CHECK;
               default:   state_in = S_DONE;
            endcase
         end
         S_CHECK: begin
            state_in = (hit || left_ff == CW'(1)) ? S_DONE : S_ISSUE;
         end
         S_DONE: begin
            if (res_ready) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = (state_ff == S_IDLE);
      res_valid = (state_ff == S_DONE);
      op_in     = op_ff;
      key_in    = key_ff;
      left_in   = left_ff;
      moved_in  = moved_ff;
      value_in  = value_ff;
      status_in = status_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               op_in     = req_operation;
               key_in    = req_key;
               left_in   = count;
               moved_in  = '0;
               value_in  = '0;
               status_in = ST_OK;
            end
         end
         S_ISSUE: begin
            unique case (op_ff)
               OP_ENQ: begin
                  if (count == CW'(DEPTH)) status_in = ST_FULL;
                  else cmd.push_key = 1'b1;
               end
               OP_DEQ: begin
                  if (count == '0) status_in = ST_EMPTY;
                  else cmd.read_head = 1'b1;
               end
               OP_SEARCH: begin
                  if (left_ff == '0) status_in = ST_NOTFOUND;
                  else cmd.read_head = 1'b1;
               end
               default: begin
               end
            endcase
         end
         S_CHECK: begin
            if (hit) begin
               cmd.pop  = 1'b1;
               value_in = rd_data;
            end else begin
               cmd.requeue = 1'b1;
               moved_in    = moved_ff + CW'(1);
               left_in     = left_ff - CW'(1);
               if (left_ff == CW'(1)) status_in = ST_NOTFOUND;
            end
         end
         S_DONE: begin
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff     <= op_in;
      key_ff    <= key_in;
      left_ff   <= left_in;
      moved_ff  <= moved_in;
      value_ff  <= value_in;
      status_ff <= status_in;
   end

   assign key             = key_ff;
   assign res.value       = value_ff;
   assign res.moved_count = CNT_W'(moved_ff);
   assign res.status      = status_ff;
   assign res.occupancy   = CNT_W'(count);

endmodule

FILE: hw/rtl/ring_queue_search_rotate_top.sv
// Top level of the ring queue with rotate search: request and response
// channels, sequencer, slot store and response register. Depends on rqsr_pkg.
//
// A bounded circular FIFO of DEPTH signed 32-bit keys. Operation 0 appends the
// key (status 1 when full), 1 removes the head (status 2 when empty), 2 removes
// the first entry equal to the key after moving every entry ahead of it to the
// tail, reporting how many were moved (status 3 with the order unchanged when
// absent). One request is handled at a time. A dequeue or a search goes step by
// step: every step is a head read from the slot memory followed by a compare
// and then either a pop of the head (on a match, or always for a dequeue) or,
// for a search that does not match, a write back at the tail.
// The result sits in an output register, so the next request is taken while it
// waits to be transferred.
module ring_queue_search_rotate_top #(
   parameter int DEPTH = rqsr_pkg::DEPTH_DEF
) (
   input  logic       clock,
   input  logic       reset,
   rqsr_req_if.sink   req_port,
   rqsr_rsp_if.source rsp_port
);
   import rqsr_pkg::*;

   localparam int CW = $clog2(DEPTH + 1);

   cmd_type          cmd;
   logic [KEY_W-1:0] key;
   logic [KEY_W-1:0] rd_data;
   logic [CW-1:0]    count;
   logic             res_valid;
   logic             res_ready;
   res_type          res;

   logic             rsp_valid_ff, rsp_valid_in;
   res_type          rsp_data_ff, rsp_data_in;

   rqsr_seq #(.DEPTH(DEPTH)) u_seq (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_port.valid),
      .req_ready     (req_port.ready),
      .req_operation (req_port.operation),
      .req_key       (req_port.key),
      .cmd           (cmd),
      .key           (key),
      .rd_data       (rd_data),
      .count         (count),
      .res_valid     (res_valid),
      .res_ready     (res_ready),
      .res           (res)
   );

   rqsr_store #(.DEPTH(DEPTH)) u_store (
      .clock   (clock),
      .reset   (reset),
      .cmd     (cmd),
      .key     (key),
      .rd_data (rd_data),
      .count   (count)
   );

   assign res_ready = !rsp_valid_ff || rsp_port.ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (res_ready) begin
         rsp_valid_in = res_valid;
         if (res_valid) rsp_data_in = res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_port.valid       = rsp_valid_ff;
   assign rsp_port.value       = rsp_data_ff.value;
   assign rsp_port.moved_count = rsp_data_ff.moved_count;
   assign rsp_port.status      = rsp_data_ff.status;
   assign rsp_port.occupancy   = rsp_data_ff.occupancy;

endmodule
